/* design/nbf_pkg.sv */
// ----------------------------------------------------------------------------
// nbf_pkg: shared definitions for the notch biquad filter
// Default widths of samples and fractions, and the register map codes.
// ----------------------------------------------------------------------------
package nbf_pkg;

  // Default sample width and number of fractional bits.
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // Integer bits of the Q8.F coefficients.
  localparam int unsigned COEF_INT_BITS = 8;

  // Configuration data and address widths.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Register index as decoded from the byte address.
  typedef enum logic {
    REG_ALPHA = 1'b0,
    REG_BETA  = 1'b1
  } reg_idx_e;

endpackage

/* design/nbf_mac.sv */
// ----------------------------------------------------------------------------
// nbf_mac: shared multiply-accumulate unit
// Forms the filter numerator with one signed multiplier over five steps.
// ----------------------------------------------------------------------------
module nbf_mac #(
  parameter int unsigned SAMPLE_BITS = nbf_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = nbf_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [FRAC_BITS+7:0]                   alpha_i,
  input  logic [FRAC_BITS+7:0]                   beta_i,
  input  logic signed [SAMPLE_BITS-1:0]          x0_i,
  input  logic signed [SAMPLE_BITS-1:0]          x1_i,
  input  logic signed [SAMPLE_BITS-1:0]          x2_i,
  input  logic signed [SAMPLE_BITS+FRAC_BITS-1:0] y1_i,
  input  logic signed [SAMPLE_BITS+FRAC_BITS-1:0] y2_i,
  output logic                                   done_o,
  output logic signed [2*FRAC_BITS+SAMPLE_BITS+11:0] acc_o
);

  localparam int unsigned COEF_BITS = FRAC_BITS + nbf_pkg::COEF_INT_BITS;
  localparam int unsigned HIST_BITS = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned CO_W      = COEF_BITS + 3;
  localparam int unsigned PROD_W    = CO_W + HIST_BITS;
  localparam int unsigned ACC_W     = PROD_W + 1;
  localparam logic signed [CO_W-1:0] EIGHT = CO_W'(8) <<< FRAC_BITS;

  typedef enum logic [2:0] {
    STEP_X0 = 3'd0,
    STEP_X1 = 3'd1,
    STEP_X2 = 3'd2,
    STEP_Y1 = 3'd3,
    STEP_Y2 = 3'd4
  } mac_step_e;

  logic                     busy_q, busy_d;
  mac_step_e                step_q, step_d;
  logic signed [CO_W-1:0]   opa_q, opa_d;
  logic signed [HIST_BITS-1:0] opb_q, opb_d;
  logic                     op_vld_q, op_last_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q, prod_last_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     done_q;

  logic signed [CO_W-1:0]   coef_a, coef_am8x2, coef_bma;

  // Coefficient terms; the user must hold alpha and beta still while an item is in work (not enforced here).
  always_comb begin
    coef_a     = $signed({3'b000, alpha_i});
    coef_am8x2 = (coef_a - EIGHT) <<< 1;
    coef_bma   = $signed({3'b000, beta_i}) - coef_a;
  end

  // Step sequencer and operand selection.
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_X0;
    end else if (busy_q) begin
      unique case (step_q)
        STEP_X0: begin
          opa_d  = coef_a;
          opb_d  = $signed({x0_i, {FRAC_BITS{1'b0}}});
          step_d = STEP_X1;
        end
        STEP_X1: begin
          opa_d  = coef_am8x2;
          opb_d  = $signed({x1_i, {FRAC_BITS{1'b0}}});
          step_d = STEP_X2;
        end
        STEP_X2: begin
          opa_d  = coef_a;
          opb_d  = $signed({x2_i, {FRAC_BITS{1'b0}}});
          step_d = STEP_Y1;
        end
        STEP_Y1: begin
          opa_d  = -coef_am8x2;
          opb_d  = y1_i;
          step_d = STEP_Y2;
        end
        STEP_Y2: begin
          opa_d  = coef_bma;
          opb_d  = y2_i;
          busy_d = 1'b0;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  // Accumulator: cleared on start, adds each registered product.
  always_comb begin
    acc_d = acc_q;
    if (start_i) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= STEP_X0;
      op_vld_q    <= 1'b0;
      op_last_q   <= 1'b0;
      prod_vld_q  <= 1'b0;
      prod_last_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      op_vld_q    <= busy_q && !start_i;
      op_last_q   <= busy_q && !start_i && (step_q == STEP_Y2);
      prod_vld_q  <= op_vld_q;
      prod_last_q <= op_last_q;
      done_q      <= prod_vld_q && prod_last_q;
    end
  end

  // Datapath registers: operands, product and sum.
  always_ff @(posedge clk_i) begin
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    prod_q <= opa_q * opb_q;
    acc_q  <= acc_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

/* design/nbf_div.sv */
// ----------------------------------------------------------------------------
// nbf_div: serial unsigned divider
// Restoring division that settles one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nbf_div #(
  parameter int unsigned SAMPLE_BITS = nbf_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = nbf_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [2*FRAC_BITS+SAMPLE_BITS+11:0]  dividend_i,
  input  logic [FRAC_BITS+8:0]                 divisor_i,
  output logic                                 done_o,
  output logic [2*FRAC_BITS+SAMPLE_BITS+11:0]  quotient_o
);

  localparam int unsigned DIV_W = 2 * FRAC_BITS + SAMPLE_BITS + 12;
  localparam int unsigned DEN_W = FRAC_BITS + 9;
  localparam int unsigned REM_W = DEN_W + 1;
  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W:0]   diff;

  // One restoring step: shift in the next dividend bit and trial-subtract.
  always_comb begin
    rem_sh = {rem_q[REM_W-2:0], quo_q[DIV_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, divisor_i};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_W);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = diff[REM_W] ? rem_sh : diff[REM_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], !diff[REM_W]};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* design/notch_biquad_filter.sv */
// Flow: an accepted sample passes the five-step shared multiply-accumulate, then the
// bit-serial divider (one quotient bit per cycle, 2*FRAC_BITS+SAMPLE_BITS+12 bits),
// then the finish state; the divider is skipped when a+b is 0. A new sample is
// accepted only after the last result enters the output register; the next one is taken
// while a finished result still waits, and a full output register holds the finish.
// Reset: asynchronous, active low; histories clear, alpha = 4.0, beta = 0.
// ----------------------------------------------------------------------------
// notch_biquad_filter: second-order IIR notch filter, fixed point
// Sequencer, coefficient registers, histories and output rounding.
// ----------------------------------------------------------------------------
module notch_biquad_filter #(
  parameter int unsigned SAMPLE_BITS = nbf_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = nbf_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: [SAMPLE_BITS-1:0] sample_in, zero padding above
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // Output stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata: [SAMPLE_BITS-1:0] sample_out, zero padding above
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
  // tuser: [0] saturated
  output logic                                   m_axis_tuser,
  // Configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [nbf_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [nbf_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [nbf_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  localparam int unsigned COEF_BITS = FRAC_BITS + nbf_pkg::COEF_INT_BITS;
  localparam int unsigned HIST_BITS = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned DIV_W     = 2 * FRAC_BITS + SAMPLE_BITS + 12;
  localparam int unsigned DEN_W     = COEF_BITS + 1;
  localparam int unsigned R_W       = DIV_W - FRAC_BITS;
  localparam int unsigned TD_W      = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [COEF_BITS-1:0] ALPHA_RST = COEF_BITS'(4) << FRAC_BITS;
  localparam logic [DIV_W-1:0] HALF_LSB = DIV_W'(1) << (FRAC_BITS - 1);
  localparam logic [R_W-1:0] SMAX_MAG =
    {{(R_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [R_W-1:0] SMIN_MAG =
    {{(R_W-SAMPLE_BITS){1'b0}}, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [DIV_W-1:0] HMAX_MAG =
    {{(DIV_W-HIST_BITS+1){1'b0}}, {(HIST_BITS-1){1'b1}}};
  localparam logic [DIV_W-1:0] HMIN_MAG =
    {{(DIV_W-HIST_BITS){1'b0}}, 1'b1, {(HIST_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [COEF_BITS-1:0]          alpha_q, beta_q;
  logic signed [SAMPLE_BITS-1:0] x0_q, x1_q, x2_q;
  logic signed [HIST_BITS-1:0]   y1_q, y2_q;
  logic                          neg_q, zero_q;
  logic                          m_valid_q;
  logic [SAMPLE_BITS-1:0]        m_sample_q, m_sample_d;
  logic                          m_sat_q, m_sat_d;

  logic                          s_xfer, m_free, cfg_wr, commit;
  logic [DEN_W-1:0]              den;
  logic [DEN_W-1:0]              den_half;
  logic                          mac_done, div_done;
  logic signed [DIV_W-1:0]       acc;
  logic [DIV_W-1:0]              dividend, quotient, q_eff, q_rnd;
  logic [R_W-1:0]                r_mag;
  logic signed [HIST_BITS-1:0]   y0;

  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign m_free = !m_valid_q || m_axis_tready;
  assign commit = (state_q == ST_FIN) && m_free;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign den      = {1'b0, alpha_q} + {1'b0, beta_q};
  assign den_half = den >> 1;

  // Configuration registers; a write is decoded on the word address bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RST;
      beta_q  <= '0;
    end else if (cfg_wr) begin
      unique case (nbf_pkg::reg_idx_e'(paddr[2]))
        nbf_pkg::REG_ALPHA: alpha_q <= pwdata[COEF_BITS-1:0];
        nbf_pkg::REG_BETA:  beta_q  <= pwdata[COEF_BITS-1:0];
        default:            alpha_q <= alpha_q;
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    prdata = '0;
    unique case (nbf_pkg::reg_idx_e'(paddr[2]))
      nbf_pkg::REG_ALPHA: prdata = nbf_pkg::APB_DATA_W'(alpha_q);
      nbf_pkg::REG_BETA:  prdata = nbf_pkg::APB_DATA_W'(beta_q);
      default:            prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // Shared multiply-accumulate forms the numerator.
  nbf_mac #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(s_xfer),
    .alpha_i(alpha_q),
    .beta_i (beta_q),
    .x0_i   (x0_q),
    .x1_i   (x1_q),
    .x2_i   (x2_q),
    .y1_i   (y1_q),
    .y2_i   (y2_q),
    .done_o (mac_done),
    .acc_o  (acc)
  );

  // Magnitude plus half the divisor, folded into one add or subtract.
  assign dividend = acc[DIV_W-1] ? (DIV_W'(den_half) - DIV_W'(acc))
                                 : (DIV_W'(acc) + DIV_W'(den_half));

  nbf_div #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   ((state_q == ST_MAC) && mac_done && (den != '0)),
    .dividend_i(dividend),
    .divisor_i (den),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_xfer) state_d = ST_MAC;
      ST_MAC: begin
        if (mac_done) state_d = (den == '0) ? ST_FIN : ST_DIV;
      end
      ST_DIV:  if (div_done) state_d = ST_FIN;
      ST_FIN:  if (m_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // Rounding to integer, saturation and the stored Q.F history value.
  always_comb begin
    q_eff = zero_q ? '0 : quotient;
    q_rnd = q_eff + HALF_LSB;
    r_mag = q_rnd[DIV_W-1:FRAC_BITS];
    m_sat_d    = 1'b0;
    m_sample_d = neg_q ? -r_mag[SAMPLE_BITS-1:0] : r_mag[SAMPLE_BITS-1:0];
    if (!neg_q && (r_mag > SMAX_MAG)) begin
      m_sat_d    = 1'b1;
      m_sample_d = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (neg_q && (r_mag > SMIN_MAG)) begin
      m_sat_d    = 1'b1;
      m_sample_d = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end
    y0 = neg_q ? -$signed(q_eff[HIST_BITS-1:0]) : $signed(q_eff[HIST_BITS-1:0]);
    if (!neg_q && (q_eff > HMAX_MAG)) begin
      y0 = $signed({1'b0, {(HIST_BITS-1){1'b1}}});
    end else if (neg_q && (q_eff > HMIN_MAG)) begin
      y0 = $signed({1'b1, {(HIST_BITS-1){1'b0}}});
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      x1_q      <= '0;
      x2_q      <= '0;
      y1_q      <= '0;
      y2_q      <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        m_valid_q <= 1'b1;
        x1_q      <= x0_q;
        x2_q      <= x1_q;
        y1_q      <= y0;
        y2_q      <= y1_q;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: current sample, numerator sign, result.
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      x0_q <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
    end
    if ((state_q == ST_MAC) && mac_done) begin
      neg_q  <= (den != '0) && acc[DIV_W-1];
      zero_q <= (den == '0);
    end
    if (commit) begin
      m_sample_q <= m_sample_d;
      m_sat_q    <= m_sat_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TD_W'(m_sample_q);
  assign m_axis_tuser  = m_sat_q;

endmodule
